// ===== rtl/core/rbi_pkg.sv =====
// rbi_pkg: shared types, operation codes and fixed-point helpers for the
// rigid body integrator core; used by every file in rtl/core
`default_nettype none
package rbi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DT_BITS       = 16;
  localparam int VEC_W         = 32;
  localparam int MASS_W        = 31;
  localparam int IN_DATA_W     = 6 * VEC_W + DT_BITS;
  localparam int OUT_DATA_W    = 9 * VEC_W;
  localparam int QDEPTH        = 2;

  // register indexes
  localparam logic [1:0] REG_TYPE    = 2'd0;
  localparam logic [1:0] REG_MASS    = 2'd1;
  localparam logic [1:0] REG_INERTIA = 2'd2;

  // body types
  localparam logic [1:0] BODY_STATIC  = 2'd0;
  localparam logic [1:0] BODY_DYNAMIC = 2'd2;

  // request kinds
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_FORCE  = 3'd1;
  localparam logic [2:0] REQ_TORQUE = 3'd2;
  localparam logic [2:0] REQ_LOADL  = 3'd3;
  localparam logic [2:0] REQ_LOADA  = 3'd4;

  // classified operations handed to the back end
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_TICK     = 4'd1;
  localparam logic [OP_W-1:0] OP_STILL    = 4'd2;
  localparam logic [OP_W-1:0] OP_FORCE    = 4'd3;
  localparam logic [OP_W-1:0] OP_ACC_ZERO = 4'd4;
  localparam logic [OP_W-1:0] OP_TORQUE   = 4'd5;
  localparam logic [OP_W-1:0] OP_AAC_ZERO = 4'd6;
  localparam logic [OP_W-1:0] OP_LDL      = 4'd7;
  localparam logic [OP_W-1:0] OP_LDL_ZERO = 4'd8;
  localparam logic [OP_W-1:0] OP_LDA      = 4'd9;
  localparam logic [OP_W-1:0] OP_LDA_ZERO = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [2:0][VEC_W-1:0]   vec;
    logic [2:0][VEC_W-1:0]   aux;
    logic [DT_BITS-1:0]      dt;
    logic [2*DT_BITS-1:0]    dt2;
  } cmd_t;

  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic [MASS_W-1:0] inertia;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // round to nearest, ties toward +inf, then arithmetic shift
  function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int s);
    logic signed [63:0] r;
    r = (x + (64'sd1 <<< (s - 1))) >>> s;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rigid_body_integrator_core.sv =====
// rigid_body_integrator_core: top level of the three-axis rigid body integrator
// depends on rbi_pkg, rbi_front, rbi_queue and rbi_back
`default_nettype none
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  s_*     | in        | s_tvalid / s_tready | tuser req_type, tdata vec, aux, dt
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//  m_*     | out       | m_tvalid / m_tready | tuser kind, tdata report, tlast
//
//  one word is worked on at a time by the back-end sequencer; the front takes
//  up to two more into the queue while it runs
//  a tick takes six steps per linear axis and four per angular axis on the one
//  shared multiplier, which load linear and torque also use per axis; a force
//  runs each axis through the one-bit-a-cycle divider
//  reset clears state to zero, body type dynamic, mass and inertia 1.0
//  a stalled output holds both reports; the sequencer waits only when it has
//  a new pair ready and the previous pair is not yet gone
module rigid_body_integrator_core #(
  parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // vec_x, vec_y, vec_z, aux_x, aux_y, aux_z, delta_time
  input  wire logic [rbi_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  wire logic [2:0]                     s_tuser,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [31:0]                    cfg_data,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // first_x, first_y, first_z, second_x..z, third_x..z
  output logic [rbi_pkg::OUT_DATA_W-1:0]      m_tdata,
  // report_kind
  output logic [0:0]                          m_tuser,
  output logic                                m_tlast
);
  logic          fq_valid;
  logic          fq_ready;
  rbi_pkg::cmd_t fq_data;
  logic          qb_valid;
  logic          qb_ready;
  rbi_pkg::cmd_t qb_data;
  rbi_pkg::cfg_t cfg;

  // intake and classification against the body type
  rbi_front u_front (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .q_valid (fq_valid), .q_ready (fq_ready), .q_data (fq_data),
    .cfg
  );

  // decouples intake from the sequencer
  rbi_queue u_queue (
    .clk, .rst,
    .wr_valid (fq_valid), .wr_ready (fq_ready), .wr_data (fq_data),
    .rd_valid (qb_valid), .rd_ready (qb_ready), .rd_data (qb_data)
  );

  // state, arithmetic and reports
  rbi_back #(.FRAC_BITS (FRAC_BITS)) u_back (
    .clk, .rst,
    .q_valid (qb_valid), .q_ready (qb_ready), .q_data (qb_data),
    .cfg,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  // the angular report always follows the linear one straight away
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
    else $error("angular report did not follow linear report");

  // the buffer is empty after the pair has gone
  a_pair_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("report buffer not empty after angular report");

  // kind and last marker agree
  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == m_tuser[0]))
    else $error("report kind and last marker disagree");
endmodule
`default_nettype wire

// ===== rtl/core/rbi_queue.sv =====
// rbi_queue: short command queue between the front and back ends
// depends on rbi_pkg for the command type and depth
`default_nettype none
module rbi_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  input  rbi_pkg::cmd_t     wr_data,
  output logic              rd_valid,
  input  wire logic         rd_ready,
  output rbi_pkg::cmd_t     rd_data
);
  localparam int PW = (rbi_pkg::QDEPTH > 1) ? $clog2(rbi_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(rbi_pkg::QDEPTH + 1);

  rbi_pkg::cmd_t mem [rbi_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != CW'(rbi_pkg::QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(rbi_pkg::QDEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(rbi_pkg::QDEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) count <= CW'(count + 1'b1);
      else if (pop && !push) count <= CW'(count - 1'b1);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/rbi_front.sv =====
// rbi_front: configuration registers, request intake and classification
// depends on rbi_pkg; feeds rbi_queue
`default_nettype none
module rbi_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [rbi_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [2:0]                    s_tuser,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [31:0]                   cfg_data,
  output logic                               q_valid,
  input  wire logic                          q_ready,
  output rbi_pkg::cmd_t                      q_data,
  output rbi_pkg::cfg_t                      cfg
);
  logic [1:0]                 body_type;
  logic [rbi_pkg::MASS_W-1:0] body_mass;
  logic [rbi_pkg::MASS_W-1:0] inertia;
  logic                       is_static;
  logic                       is_dynamic;
  logic [rbi_pkg::OP_W-1:0]   op;
  logic [rbi_pkg::DT_BITS-1:0] dt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_type <= rbi_pkg::BODY_DYNAMIC;
      body_mass <= rbi_pkg::MASS_W'(65536);
      inertia   <= rbi_pkg::MASS_W'(65536);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rbi_pkg::REG_TYPE: body_type <= cfg_data[1:0];
        rbi_pkg::REG_MASS: begin
          if (cfg_data[30:0] != '0) body_mass <= cfg_data[30:0];
        end
        rbi_pkg::REG_INERTIA: begin
          if (cfg_data[30:0] != '0) inertia <= cfg_data[30:0];
        end
        default: ;
      endcase
    end
  end

  assign cfg.mass    = body_mass;
  assign cfg.inertia = inertia;

  assign is_static  = (body_type == rbi_pkg::BODY_STATIC);
  assign is_dynamic = (body_type == rbi_pkg::BODY_DYNAMIC);

  always_comb begin
    unique case (s_tuser)
      rbi_pkg::REQ_TICK:   op = is_static  ? rbi_pkg::OP_STILL    : rbi_pkg::OP_TICK;
      rbi_pkg::REQ_FORCE:  op = is_dynamic ? rbi_pkg::OP_FORCE    : rbi_pkg::OP_ACC_ZERO;
      rbi_pkg::REQ_TORQUE: op = is_dynamic ? rbi_pkg::OP_TORQUE   : rbi_pkg::OP_AAC_ZERO;
      rbi_pkg::REQ_LOADL:  op = is_static  ? rbi_pkg::OP_LDL_ZERO : rbi_pkg::OP_LDL;
      rbi_pkg::REQ_LOADA:  op = is_static  ? rbi_pkg::OP_LDA_ZERO : rbi_pkg::OP_LDA;
      default:             op = rbi_pkg::OP_NONE;
    endcase
  end

  assign dt = s_tdata[6*rbi_pkg::VEC_W +: rbi_pkg::DT_BITS];

  always_comb begin
    q_data.op     = op;
    q_data.vec[0] = s_tdata[0*rbi_pkg::VEC_W +: rbi_pkg::VEC_W];
    q_data.vec[1] = s_tdata[1*rbi_pkg::VEC_W +: rbi_pkg::VEC_W];
    q_data.vec[2] = s_tdata[2*rbi_pkg::VEC_W +: rbi_pkg::VEC_W];
    q_data.aux[0] = s_tdata[3*rbi_pkg::VEC_W +: rbi_pkg::VEC_W];
    q_data.aux[1] = s_tdata[4*rbi_pkg::VEC_W +: rbi_pkg::VEC_W];
    q_data.aux[2] = s_tdata[5*rbi_pkg::VEC_W +: rbi_pkg::VEC_W];
    q_data.dt     = dt;
    // dt squared, registered by the queue
    q_data.dt2    = (2*rbi_pkg::DT_BITS)'(dt) * (2*rbi_pkg::DT_BITS)'(dt);
  end

  assign q_valid  = s_tvalid;
  assign s_tready = q_ready;
endmodule
`default_nettype wire

// ===== rtl/core/rbi_back.sv =====
// rbi_back: state registers, sequencer with a shared multiplier and a
// bit-serial divider, and the two-report output buffer; depends on rbi_pkg
`default_nettype none
module rbi_back #(
  parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  rbi_pkg::cmd_t                       q_data,
  input  rbi_pkg::cfg_t                       cfg,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [rbi_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [0:0]                          m_tuser,
  output logic                                m_tlast
);
  localparam int NW    = 32 + FRAC_BITS;
  localparam int DCW   = $clog2(NW);
  localparam int SUM_W = 36;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_VDT  = 4'd2;
  localparam logic [3:0] ST_ADT2 = 4'd3;
  localparam logic [3:0] ST_ADT  = 4'd4;
  localparam logic [3:0] ST_XV   = 4'd5;
  localparam logic [3:0] ST_MMUL = 4'd6;
  localparam logic [3:0] ST_MOM  = 4'd7;
  localparam logic [3:0] ST_TMUL = 4'd8;
  localparam logic [3:0] ST_TQ   = 4'd9;
  localparam logic [3:0] ST_DSET = 4'd10;
  localparam logic [3:0] ST_DIV  = 4'd11;
  localparam logic [3:0] ST_DFIN = 4'd12;
  localparam logic [3:0] ST_EMIT = 4'd13;

  logic [3:0]         state;
  rbi_pkg::cmd_t      cur;
  logic [1:0]         ax;
  logic               ang;

  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] mom [3];
  logic signed [31:0] ori [3];
  logic signed [31:0] avl [3];
  logic signed [31:0] acc [3];
  logic signed [31:0] aac [3];

  logic signed [63:0]      prod;
  logic signed [SUM_W-1:0] sum;
  logic [NW-1:0]           dnum;
  logic [31:0]             drem;
  logic [DCW-1:0]          dcnt;
  logic                    dneg;

  logic                    out_valid;
  logic                    out_second;
  logic [rbi_pkg::OUT_DATA_W-1:0] rep_lin;
  logic [rbi_pkg::OUT_DATA_W-1:0] rep_ang;

  logic signed [31:0] x_sel;
  logic signed [31:0] v_sel;
  logic signed [31:0] a_sel;
  logic signed [31:0] f_sel;
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] mul_full;
  logic signed [31:0] nx;
  logic signed [31:0] nv;
  logic [31:0]        mag;
  logic [31:0]        trial;
  logic               take;
  logic               big;

  assign x_sel = ang ? ori[ax] : pos[ax];
  assign v_sel = ang ? avl[ax] : vel[ax];
  assign a_sel = ang ? aac[ax] : acc[ax];
  assign f_sel = $signed(cur.vec[ax]);

  always_comb begin
    unique case (state)
      ST_VDT:  begin mul_a = v_sel;   mul_b = $signed({17'b0, cur.dt}); end
      ST_ADT2: begin mul_a = a_sel;   mul_b = $signed({1'b0, cur.dt2}); end
      ST_ADT:  begin mul_a = a_sel;   mul_b = $signed({17'b0, cur.dt}); end
      ST_MMUL: begin mul_a = vel[ax]; mul_b = $signed({2'b0, cfg.mass}); end
      ST_TMUL: begin mul_a = f_sel;   mul_b = $signed({2'b0, cfg.inertia}); end
      default: begin mul_a = '0;      mul_b = '0; end
    endcase
  end

  assign mul_full = 65'(mul_a) * 65'(mul_b);

  assign nx = rbi_pkg::sat32(64'(x_sel) + 64'(sum));
  assign nv = rbi_pkg::sat32(64'(v_sel) + rbi_pkg::rnd(prod, rbi_pkg::DT_BITS));

  assign mag   = f_sel[31] ? 32'(~f_sel + 1'b1) : 32'(f_sel);
  assign trial = {drem[30:0], dnum[NW-1]};
  assign take  = (trial >= {1'b0, cfg.mass});
  assign big   = |dnum[NW-1:31];

  assign q_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ax    <= '0;
      ang   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0; vel[i] <= '0; mom[i] <= '0;
        ori[i] <= '0; avl[i] <= '0; acc[i] <= '0; aac[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur   <= q_data;
            ax    <= '0;
            ang   <= 1'b0;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          unique case (cur.op)
            rbi_pkg::OP_STILL: begin
              for (int i = 0; i < 3; i++) begin vel[i] <= '0; avl[i] <= '0; end
            end
            rbi_pkg::OP_ACC_ZERO: for (int i = 0; i < 3; i++) acc[i] <= '0;
            rbi_pkg::OP_AAC_ZERO: for (int i = 0; i < 3; i++) aac[i] <= '0;
            rbi_pkg::OP_LDL: begin
              for (int i = 0; i < 3; i++) begin
                pos[i] <= $signed(cur.vec[i]);
                vel[i] <= $signed(cur.aux[i]);
              end
            end
            rbi_pkg::OP_LDL_ZERO: begin
              for (int i = 0; i < 3; i++) begin
                pos[i] <= $signed(cur.vec[i]); vel[i] <= '0; mom[i] <= '0;
              end
            end
            rbi_pkg::OP_LDA: begin
              for (int i = 0; i < 3; i++) begin
                ori[i] <= $signed(cur.vec[i]);
                avl[i] <= $signed(cur.aux[i]);
              end
            end
            rbi_pkg::OP_LDA_ZERO: begin
              for (int i = 0; i < 3; i++) begin
                ori[i] <= $signed(cur.vec[i]); avl[i] <= '0;
              end
            end
            default: ;
          endcase
          unique case (cur.op)
            rbi_pkg::OP_TICK:   state <= ST_VDT;
            rbi_pkg::OP_FORCE:  state <= ST_DSET;
            rbi_pkg::OP_TORQUE: state <= ST_TMUL;
            rbi_pkg::OP_LDL:    state <= ST_MMUL;
            default:            state <= ST_EMIT;
          endcase
        end
        ST_VDT:  state <= ST_ADT2;
        ST_ADT2: begin
          sum   <= SUM_W'(rbi_pkg::rnd(prod, rbi_pkg::DT_BITS));
          state <= ST_ADT;
        end
        ST_ADT: begin
          sum   <= sum + SUM_W'(rbi_pkg::rnd(prod, 2 * rbi_pkg::DT_BITS + 1));
          state <= ST_XV;
        end
        ST_XV: begin
          if (ang) begin
            ori[ax] <= nx;
            avl[ax] <= nv;
            if (ax == 2'd2) begin
              ax    <= '0;
              state <= ST_EMIT;
            end else begin
              ax    <= ax + 2'd1;
              state <= ST_VDT;
            end
          end else begin
            pos[ax] <= nx;
            vel[ax] <= nv;
            state   <= ST_MMUL;
          end
        end
        ST_MMUL: state <= ST_MOM;
        ST_MOM: begin
          mom[ax] <= rbi_pkg::sat32(rbi_pkg::rnd(prod, FRAC_BITS));
          if (ax == 2'd2) begin
            ax <= '0;
            if (cur.op == rbi_pkg::OP_TICK) begin
              ang   <= 1'b1;
              state <= ST_VDT;
            end else begin
              state <= ST_EMIT;
            end
          end else begin
            ax    <= ax + 2'd1;
            state <= (cur.op == rbi_pkg::OP_TICK) ? ST_VDT : ST_MMUL;
          end
        end
        ST_TMUL: state <= ST_TQ;
        ST_TQ: begin
          aac[ax] <= rbi_pkg::sat32(rbi_pkg::rnd(prod, FRAC_BITS));
          if (ax == 2'd2) begin
            ax    <= '0;
            state <= ST_EMIT;
          end else begin
            ax    <= ax + 2'd1;
            state <= ST_TMUL;
          end
        end
        ST_DSET: begin
          dnum  <= (NW'(mag) << FRAC_BITS) + NW'(cfg.mass >> 1);
          drem  <= '0;
          dcnt  <= '0;
          dneg  <= f_sel[31];
          state <= ST_DIV;
        end
        ST_DIV: begin
          drem <= take ? (trial - {1'b0, cfg.mass}) : trial;
          dnum <= {dnum[NW-2:0], take};
          dcnt <= DCW'(dcnt + 1'b1);
          if (dcnt == DCW'(NW - 1)) state <= ST_DFIN;
        end
        ST_DFIN: begin
          if (dneg) acc[ax] <= big ? 32'sh80000000 : $signed(32'(-dnum[31:0]));
          else      acc[ax] <= big ? 32'sh7fffffff : $signed(dnum[31:0]);
          if (ax == 2'd2) begin
            ax    <= '0;
            state <= ST_EMIT;
          end else begin
            ax    <= ax + 2'd1;
            state <= ST_DSET;
          end
        end
        ST_EMIT: begin
          if (!out_valid) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // report buffer: both reports snapshot at once, linear goes first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      out_second <= 1'b0;
    end else if (state == ST_EMIT && !out_valid) begin
      out_valid  <= 1'b1;
      out_second <= 1'b0;
    end else if (out_valid && m_tready) begin
      if (out_second) out_valid <= 1'b0;
      out_second <= !out_second;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && !out_valid) begin
      rep_lin <= {mom[2], mom[1], mom[0], vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
      rep_ang <= {aac[2], aac[1], aac[0], avl[2], avl[1], avl[0], ori[2], ori[1], ori[0]};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_second ? rep_ang : rep_lin;
  assign m_tuser  = out_second;
  assign m_tlast  = out_second;
endmodule
`default_nettype wire

// ===== verif/rbi_checker.sv =====
// rbi_checker: watches the request, config and report channels of the rigid
// body integrator, predicts each report pair and compares; depends on rbi_pkg
module rbi_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  input  wire logic                          s_tready,
  input  wire logic [rbi_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [2:0]                    s_tuser,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  wire logic                          m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic [rbi_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire logic [0:0]                    m_tuser,
  input  wire logic                          m_tlast,
  output int                                 errors,
  output int                                 pending,
  output int                                 reports_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import rbi_pkg::*;

  typedef logic signed [31:0] s32_t;
  typedef s32_t vec3_t [3];

  typedef struct {
    logic                        kind;
    logic [OUT_DATA_W-1:0]       data;
    logic                        last;
  } report_t;

  report_t report_q [$];

  logic [1:0]  body;
  logic [30:0] mass, inertia;
  vec3_t pos, vel, mom, ori, avel, acc, aacc;

  function automatic s32_t clamp(input logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'sh7fffffff;
    if (x < -128'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // nearest, ties upward: floor((x + half) / 2^s)
  function automatic logic signed [127:0] round_down(input logic signed [127:0] x, input int s);
    return (x + (128'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic s32_t scale(input s32_t a, input logic [30:0] b);
    logic signed [127:0] p;
    p = 128'(a) * $signed({97'd0, b});
    return clamp(round_down(p, 16));
  endfunction

  // (|f| << 16 + m/2) / m, capped at 2^32, sign restored
  function automatic s32_t per_mass(input s32_t f, input logic [30:0] m);
    logic [63:0] mag, q;
    mag = f < 0 ? 64'(-64'(f)) : 64'(f);
    q = ((mag << 16) + 64'(m >> 1)) / 64'(m);
    if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    return clamp(f < 0 ? -$signed({64'd0, q}) : $signed({64'd0, q}));
  endfunction

  task automatic advance(inout vec3_t x, inout vec3_t v, input vec3_t a,
                         input logic [15:0] dt);
    logic signed [127:0] vdt, adt2, adt, dsq;
    dsq = $signed({96'd0, 32'(dt) * 32'(dt)});
    for (int i = 0; i < 3; i++) begin
      vdt  = round_down(128'(v[i]) * $signed({112'd0, dt}), 16);
      adt2 = round_down(128'(a[i]) * dsq, 33);
      adt  = round_down(128'(a[i]) * $signed({112'd0, dt}), 16);
      x[i] = clamp(128'(x[i]) + vdt + adt2);
      v[i] = clamp(128'(v[i]) + adt);
    end
  endtask

  function automatic logic [OUT_DATA_W-1:0] pack3(input vec3_t f, input vec3_t s,
                                                  input vec3_t t);
    logic [OUT_DATA_W-1:0] d;
    for (int i = 0; i < 3; i++) begin
      d[32*i +: 32]      = f[i];
      d[32*(3+i) +: 32]  = s[i];
      d[32*(6+i) +: 32]  = t[i];
    end
    return d;
  endfunction

  task automatic apply_request(input logic [2:0] req, input logic [IN_DATA_W-1:0] d);
    vec3_t v, x;
    logic [15:0] dt;
    logic still, dyn;
    report_t r;
    for (int i = 0; i < 3; i++) begin
      v[i] = d[32*i +: 32];
      x[i] = d[32*(3+i) +: 32];
    end
    dt = d[192 +: 16];
    still = (body == BODY_STATIC);
    dyn = (body == BODY_DYNAMIC);
    case (req)
      REQ_TICK: begin
        if (!still) begin
          advance(pos, vel, acc, dt);
          for (int i = 0; i < 3; i++) mom[i] = scale(vel[i], mass);
          advance(ori, avel, aacc, dt);
        end else begin
          for (int i = 0; i < 3; i++) begin
            vel[i] = 0;
            avel[i] = 0;
          end
        end
      end
      REQ_FORCE:  for (int i = 0; i < 3; i++) acc[i] = dyn ? per_mass(v[i], mass) : 0;
      REQ_TORQUE: for (int i = 0; i < 3; i++) aacc[i] = dyn ? scale(v[i], inertia) : 0;
      REQ_LOADL: begin
        for (int i = 0; i < 3; i++) begin
          pos[i] = v[i];
          vel[i] = still ? 0 : x[i];
          mom[i] = still ? 0 : scale(x[i], mass);
        end
      end
      REQ_LOADA: begin
        for (int i = 0; i < 3; i++) begin
          ori[i] = v[i];
          avel[i] = still ? 0 : x[i];
        end
      end
      default: ;
    endcase
    r.kind = 1'b0; r.last = 1'b0; r.data = pack3(pos, vel, mom);
    report_q.push_back(r);
    r.kind = 1'b1; r.last = 1'b1; r.data = pack3(ori, avel, aacc);
    report_q.push_back(r);
  endtask

  assign pending = report_q.size();

  always @(posedge clk) begin
    report_t e;
    if (rst) begin
      body <= BODY_DYNAMIC;
      mass <= 31'd65536;
      inertia <= 31'd65536;
      for (int i = 0; i < 3; i++) begin
        pos[i] = 0; vel[i] = 0; mom[i] = 0; ori[i] = 0;
        avel[i] = 0; acc[i] = 0; aacc[i] = 0;
      end
      report_q.delete();
      errors <= 0;
      reports_seen <= 0;
    end else begin
      // config only changes while idle, so order against requests is moot
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TYPE:    body <= cfg_data[1:0];
          REG_MASS:    if (cfg_data[30:0] != 0) mass <= cfg_data[30:0];
          REG_INERTIA: if (cfg_data[30:0] != 0) inertia <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) apply_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        reports_seen <= reports_seen + 1;
        if (report_q.size() == 0) begin
          $display("%0t: unexpected report word kind=%0d", $time, m_tuser);
          errors <= errors + 1;
        end else begin
          e = report_q.pop_front();
          if (e.kind !== m_tuser[0] || e.last !== m_tlast || e.data !== m_tdata) begin
            $display("%0t: report mismatch kind exp %0d got %0d, last exp %0d got %0d",
                     $time, e.kind, m_tuser, e.last, m_tlast);
            $display("  data exp %h", e.data);
            $display("  data got %h", m_tdata);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/rigid_body_integrator_core_tb.sv =====
// rigid_body_integrator_core_tb: drives requests and register writes into the
// integrator core; rbi_checker predicts and compares, this module gives the verdict
module rigid_body_integrator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbi_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0, s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic m_tvalid, m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic m_tlast;
  int errors, pending, reports_seen;
  int cycles = 0;
  int words_sent = 0;
  bit calm = 1'b0;   // no idling in the closing stretch

  // whole-run limit; the slowest word is a force through the divider on each axis, plus stalls on two reports
  localparam int CYCLE_LIMIT = 1_500_000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rigid_body_integrator_core u_dut (.*);

  rbi_checker u_check (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // report side back-pressure: random stall bursts until the calm stretch
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(negedge clk);
    end
  end

  function automatic logic [31:0] edge_val();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      4: return 32'h00010000;
      5: return 32'hffff0000;
      6, 7: return $urandom_range(0, 32'h3ffff) - 32'h20000;  // modest values
      default: return $urandom;
    endcase
  endfunction

  // valid stays high between back-to-back words and drops only for idling or a drain
  task automatic send_word(input logic [2:0] req, input logic [31:0] v[6],
                           input logic [15:0] dt);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 8);
      repeat (n) @(negedge clk);
    end
    s_tuser <= req;
    for (int i = 0; i < 6; i++) s_tdata[32*i +: 32] <= v[i];
    s_tdata[192 +: 16] <= dt;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic random_word();
    logic [31:0] v[6];
    logic [2:0] req;
    logic [15:0] dt;
    int sel;
    for (int i = 0; i < 6; i++) v[i] = edge_val();
    sel = $urandom_range(0, 19);
    if (sel < 7) req = REQ_TICK;
    else if (sel < 10) req = REQ_FORCE;
    else if (sel < 13) req = REQ_TORQUE;
    else if (sel < 16) req = REQ_LOADL;
    else if (sel < 19) req = REQ_LOADA;
    else req = 3'($urandom_range(5, 7));
    case ($urandom_range(0, 4))
      0: dt = 16'hffff;
      1: dt = 16'h0;
      default: dt = $urandom;
    endcase
    send_word(req, v, dt);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  initial begin
    logic [31:0] v[6];
    int reqs_per_phase;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every request kind with extreme fields on the reset body
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 6; i++) v[i] = (k % 2) ? 32'h7fffffff : 32'h80000000;
      send_word(3'(k), v, (k % 2) ? 16'hffff : 16'h0001);
    end
    for (int i = 0; i < 6; i++) v[i] = 32'hfffe8000;
    send_word(REQ_FORCE, v, 16'h0);
    send_word(REQ_TORQUE, v, 16'h0);
    send_word(REQ_TICK, v, 16'hffff);
    send_word(REQ_TICK, v, 16'h0);
    drain();

    // phases over body types, masses and inertias, extremes included;
    // zero writes must leave the registers alone
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_TYPE, 32'($urandom_range(0, 3)) | (ph == 0 ? 32'hfffffffc : 32'h0));
      case (ph % 4)
        0: write_reg(REG_MASS, 32'h7fffffff);
        1: write_reg(REG_MASS, 32'h1);
        2: write_reg(REG_MASS, 32'h0);
        default: write_reg(REG_MASS, $urandom);
      endcase
      case (ph % 3)
        0: write_reg(REG_INERTIA, 32'h1);
        1: write_reg(REG_INERTIA, 32'hffffffff);
        default: write_reg(REG_INERTIA, (ph == 5) ? 32'h80000000 : $urandom);
      endcase
      if (ph == 7) write_reg(2'd3, $urandom);
      if (ph == 11) calm = 1'b1;
      reqs_per_phase = 75;
      repeat (reqs_per_phase) random_word();
      drain();
    end

    $display("sent %0d request words over 12 register settings, %0d report words checked",
             words_sent, reports_seen);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
